// ===== rtl/lfps_pkg.sv =====
// shared types, widths and constants for the line follower pid steering block
package lfps_pkg;

    // sizing
    localparam int NUM_SENSORS   = 9;
    localparam int INTEGRAL_BITS = 16;
    localparam int GAIN_W        = 10;
    localparam int ERR_W         = 4;
    localparam int DIFF_W        = ERR_W + 1;
    localparam int DISP_W        = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int IDX_W         = $clog2(NUM_SENSORS + 1);
    localparam int POS_W         = IDX_W + 2;
    localparam int PROD_W        = GAIN_W + 1 + INTEGRAL_BITS;
    localparam int ACC_W         = PROD_W + 1;
    localparam int DISP_SHIFT    = 8;
    localparam int NUM_W         = ACC_W - 1 + DISP_SHIFT;
    localparam int DIV_W         = GAIN_W + 5;
    localparam int CNT_W         = $clog2(NUM_W);
    localparam int PC_W          = 4;

    // register reset values and indexes
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(200);
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(20);
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(80);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = CFG_IDX_W'(2);

    // position and error limits
    localparam logic signed [POS_W-1:0] POS_OFFSET   = POS_W'(5);
    localparam logic signed [POS_W-1:0] POS_MAX      = POS_W'(7);
    localparam logic signed [POS_W-1:0] POS_MIN      = -POS_W'(8);
    localparam logic signed [ERR_W-1:0] ERR_LOST_POS = ERR_W'(5);
    localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -ERR_W'(5);
    localparam logic [NUM_W-1:0]        DISP_LIMIT   = NUM_W'(256);

    // microcode fields
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_POS,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_P,
        MS_I,
        MS_D
    } t_msel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD
    } t_acc;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_LOOP,
        JMP_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        t_acc  acc;
        t_jmp  jmp;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

    // program addresses
    localparam t_pc STEP_IDLE  = PC_W'(0);
    localparam t_pc STEP_POS   = PC_W'(1);
    localparam t_pc STEP_MULP  = PC_W'(2);
    localparam t_pc STEP_MULI  = PC_W'(3);
    localparam t_pc STEP_MULD  = PC_W'(4);
    localparam t_pc STEP_SUM   = PC_W'(5);
    localparam t_pc STEP_DIVI  = PC_W'(6);
    localparam t_pc STEP_DIVS  = PC_W'(7);
    localparam t_pc STEP_DONE  = PC_W'(8);

endpackage

// ===== rtl/lfps_seq.sv =====
// microcode sequencer: program rom, step counter and conditional jumps
module lfps_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lfps_pkg::t_status i_status,
    output lfps_pkg::t_ctrl   o_ctrl
);
    import lfps_pkg::*;

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;

    // control store
    function automatic t_ctrl rom(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_NOP, msel: MS_NONE, acc: ACC_HOLD, jmp: JMP_NEXT, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE: begin
                w.op  = OP_LOAD;
                w.jmp = JMP_WAIT_IN;
            end
            STEP_POS: begin
                w.op  = OP_POS;
                w.acc = ACC_CLR;
            end
            STEP_MULP: begin
                w.msel = MS_P;
            end
            STEP_MULI: begin
                w.msel = MS_I;
                w.acc  = ACC_ADD;
            end
            STEP_MULD: begin
                w.msel = MS_D;
                w.acc  = ACC_ADD;
            end
            STEP_SUM: begin
                w.acc = ACC_ADD;
            end
            STEP_DIVI: begin
                w.op = OP_DIVINIT;
            end
            STEP_DIVS: begin
                w.op  = OP_DIVSTEP;
                w.jmp = JMP_LOOP;
            end
            STEP_DONE: begin
                w.op     = OP_DONE;
                w.jmp    = JMP_WAIT_OUT;
                w.target = STEP_IDLE;
            end
            default: begin
                w.jmp    = JMP_WAIT_OUT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    assign w_ctrl = rom(r_pc);
    assign o_ctrl = w_ctrl;

    // next step
    always_comb begin
        unique case (w_ctrl.jmp)
            JMP_NEXT:     n_pc = r_pc + 1'b1;
            JMP_WAIT_IN:  n_pc = i_valid ? r_pc + 1'b1 : r_pc;
            JMP_LOOP:     n_pc = i_status.div_last ? r_pc + 1'b1 : r_pc;
            JMP_WAIT_OUT: n_pc = i_status.out_free ? w_ctrl.target : r_pc;
            default:      n_pc = STEP_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/lfps_dp.sv =====
// datapath: gains, position encoder, integral, shared multiplier, serial divider
module lfps_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lfps_pkg::t_ctrl                       i_ctrl,
    output lfps_pkg::t_status                     o_status,
    input  logic                                  i_valid,
    input  logic [lfps_pkg::NUM_SENSORS-1:0]      i_sensor_bits,
    input  logic                                  i_cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lfps_pkg::GAIN_W-1:0]           i_cfg_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [lfps_pkg::DISP_W-1:0]    o_steer_displacement,
    output logic signed [lfps_pkg::ERR_W-1:0]     o_pos_error,
    output logic                                  o_line_lost
);
    import lfps_pkg::*;

    logic [GAIN_W-1:0]               r_kp;
    logic [GAIN_W-1:0]               r_ki;
    logic [GAIN_W-1:0]               r_kd;
    logic [NUM_SENSORS-1:0]          r_bits;
    logic signed [INTEGRAL_BITS-1:0] r_sum;
    logic signed [ERR_W-1:0]         r_last;
    logic signed [ERR_W-1:0]         r_err;
    logic signed [DIFF_W-1:0]        r_diff;
    logic                            r_lost;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]         r_acc;
    logic [NUM_W-1:0]                r_num;
    logic [DIV_W-1:0]                r_rem;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_neg;
    logic                            r_ovalid;
    logic signed [DISP_W-1:0]        r_disp;
    logic signed [ERR_W-1:0]         r_oerr;
    logic                            r_olost;

    logic [IDX_W-1:0]                w_last_idx;
    logic [IDX_W-1:0]                w_zero_cnt;
    logic                            w_lost;
    logic signed [POS_W-1:0]         w_pos;
    logic signed [ERR_W-1:0]         w_err;
    logic signed [INTEGRAL_BITS:0]   w_sum_ext;
    logic signed [INTEGRAL_BITS-1:0] w_sum_sat;
    logic signed [GAIN_W:0]          w_mul_a;
    logic signed [INTEGRAL_BITS-1:0] w_mul_b;
    logic signed [PROD_W-1:0]        w_prod;
    logic [DIV_W-1:0]                w_divisor;
    logic [ACC_W-1:0]                w_mag;
    logic [DIV_W:0]                  w_trial;
    logic [DIV_W:0]                  w_diff_rem;
    logic                            w_qbit;
    logic [DISP_W-1:0]               w_qmag;
    logic                            w_out_free;

    // gains and divisor 4kp + 10ki + 10kd
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= GAIN_PROP_RST;
            r_ki <= GAIN_INTEG_RST;
            r_kd <= GAIN_DERIV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_PROP:  r_kp <= i_cfg_data;
                CFG_GAIN_INTEG: r_ki <= i_cfg_data;
                CFG_GAIN_DERIV: r_kd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_divisor = DIV_W'({r_kp, 2'b00})
                     + DIV_W'({r_ki, 3'b000}) + DIV_W'({r_ki, 1'b0})
                     + DIV_W'({r_kd, 3'b000}) + DIV_W'({r_kd, 1'b0});

    // line position from the sensor frame
    always_comb begin
        w_last_idx = '0;
        w_zero_cnt = '0;
        for (int k = 0; k < NUM_SENSORS; k++) begin
            if (!r_bits[k]) begin
                w_last_idx = IDX_W'(k + 1);
                w_zero_cnt = w_zero_cnt + 1'b1;
            end
        end
        w_lost = (w_zero_cnt == '0);
        w_pos  = $signed({2'b00, w_last_idx}) - $signed({3'b000, w_zero_cnt[IDX_W-1:1]})
               - POS_OFFSET;
        if (w_lost) begin
            w_err = (r_sum > 0) ? ERR_LOST_POS : ERR_LOST_NEG;
        end else if (w_pos > POS_MAX) begin
            w_err = ERR_W'(POS_MAX);
        end else if (w_pos < POS_MIN) begin
            w_err = ERR_W'(POS_MIN);
        end else begin
            w_err = w_pos[ERR_W-1:0];
        end
    end

    // saturating integral update
    always_comb begin
        w_sum_ext = {r_sum[INTEGRAL_BITS-1], r_sum}
                  + {{(INTEGRAL_BITS + 1 - ERR_W){w_err[ERR_W-1]}}, w_err};
        if (w_sum_ext[INTEGRAL_BITS] != w_sum_ext[INTEGRAL_BITS-1]) begin
            w_sum_sat = w_sum_ext[INTEGRAL_BITS]
                      ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                      : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_ext[INTEGRAL_BITS-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (i_ctrl.msel)
            MS_P: begin
                w_mul_a = $signed({1'b0, r_kp});
                w_mul_b = {{(INTEGRAL_BITS - ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            MS_I: begin
                w_mul_a = $signed({1'b0, r_ki});
                w_mul_b = r_sum;
            end
            MS_D: begin
                w_mul_a = $signed({1'b0, r_kd});
                w_mul_b = {{(INTEGRAL_BITS - DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod = w_mul_a * w_mul_b;
    end

    // divider step: restoring, one quotient bit per cycle
    assign w_mag      = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_trial    = {r_rem, r_num[NUM_W-1]};
    assign w_diff_rem = w_trial - {1'b0, w_divisor};
    assign w_qbit     = (w_trial >= {1'b0, w_divisor});

    // clamp quotient to the steering range
    assign w_qmag = (r_num > DISP_LIMIT) ? DISP_W'(DISP_LIMIT) : r_num[DISP_W-1:0];

    assign w_out_free = !r_ovalid || !i_stall;

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_ctrl.op == OP_POS) begin
            r_sum  <= w_sum_sat;
            r_last <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_LOAD && i_valid) begin
            r_bits <= i_sensor_bits;
        end
        if (i_ctrl.op == OP_POS) begin
            r_err  <= w_err;
            r_diff <= DIFF_W'(w_err) - DIFF_W'(r_last);
            r_lost <= w_lost;
        end
        if (i_ctrl.msel != MS_NONE) begin
            r_prod <= w_prod;
        end
        case (i_ctrl.acc)
            ACC_CLR: r_acc <= '0;
            ACC_ADD: r_acc <= r_acc + ACC_W'(r_prod);
            default: ;
        endcase
        case (i_ctrl.op)
            OP_DIVINIT: begin
                r_num <= {w_mag[ACC_W-2:0], {DISP_SHIFT{1'b0}}};
                r_rem <= '0;
                r_cnt <= CNT_W'(NUM_W - 1);
                r_neg <= r_acc[ACC_W-1];
            end
            OP_DIVSTEP: begin
                r_num <= {r_num[NUM_W-2:0], w_qbit};
                r_rem <= w_qbit ? w_diff_rem[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.op == OP_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_DONE && w_out_free) begin
            if (w_divisor == '0) begin
                r_disp <= '0;
            end else begin
                r_disp <= r_neg ? -$signed(w_qmag) : $signed(w_qmag);
            end
            r_oerr  <= r_err;
            r_olost <= r_lost;
        end
    end

    assign o_status.div_last = (r_cnt == '0);
    assign o_status.out_free = w_out_free;

    assign o_valid              = r_ovalid;
    assign o_steer_displacement = r_disp;
    assign o_pos_error          = r_oerr;
    assign o_line_lost          = r_olost;

endmodule

// ===== rtl/line_follower_pid_steer.sv =====
// pid steering correction for a line follower: sequencer plus datapath
// sequence from an accepted frame beat to its result beat: six setup steps,
// the restoring divider loop and one result step
// one frame in flight; the result step waits while the previous result beat is stalled,
// and the input stays stalled meanwhile
// reset (synchronous, active low): gains 200/20/80, integral and previous error zero
module line_follower_pid_steer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [lfps_pkg::NUM_SENSORS-1:0]      i_sensor_bits,
    input  logic                                  i_cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lfps_pkg::GAIN_W-1:0]           i_cfg_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [lfps_pkg::DISP_W-1:0]    o_steer_displacement,
    output logic signed [lfps_pkg::ERR_W-1:0]     o_pos_error,
    output logic                                  o_line_lost
);
    import lfps_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;

    // program sequencer
    lfps_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // datapath
    lfps_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctrl               (w_ctrl),
        .o_status             (w_status),
        .i_valid              (i_valid),
        .i_sensor_bits        (i_sensor_bits),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_steer_displacement (o_steer_displacement),
        .o_pos_error          (o_pos_error),
        .o_line_lost          (o_line_lost)
    );

    // input beat taken only at the idle step
    assign o_stall = (w_ctrl.op != OP_LOAD);

endmodule
